### src/frip_pkg.sv
// Shared types, character codes and small arithmetic helpers for the
// flight record info parser. No dependencies.
package frip_pkg;

  // Parse phases, one per '|' separated field
  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_DATE  = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_DUR   = 3'd3;
  localparam logic [2:0] PH_TAIL  = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // Number slot that marks "third number finished"
  localparam logic [1:0] IDX_DONE = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Saturation limits
  localparam logic [19:0] YEAR_LIMIT = 20'd65535;
  localparam logic [19:0] NUM_LIMIT  = 20'd255;

  // Clock arithmetic
  localparam int unsigned SIXTY     = 60;
  localparam int unsigned DIV60_MAX = 8;   // sums stay below 9 * 60
  // h / 24 as (h * 683) >> 14, exact for h below 1024
  localparam logic [9:0] MOD24_RECIP = 10'd683;
  localparam int unsigned MOD24_SHIFT = 14;

  // Date and start time carried with a finished record
  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } rec_head_t;

  // Quotient by 60 of a value below 9 * 60: compare ladder
  function automatic logic [3:0] div60(input logic [9:0] v);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= DIV60_MAX; k++) begin
      if (v >= 10'(k * SIXTY)) begin
        q = 4'(k);
      end
    end
    return q;
  endfunction

  // Multiply a quotient by 60 with shifts
  function automatic logic [9:0] times60(input logic [3:0] q);
    return {q, 6'b0} - {4'b0, q, 2'b0};
  endfunction

endpackage

### src/flight_record_info_parser_core.sv
// Flight record info parser: byte-serial parse state and a short result
// pipeline that adds the duration to the start time.
// Depends on frip_pkg.
//
// Usage:
//   Input channel: text_byte / end_of_text beats on in_valid, held off by
//   in_stall. One record is a '|' separated text; the beat with
//   end_of_text set closes it. A zero byte ends the text early, later
//   bytes up to end_of_text are ignored.
//   Output channel: one result per record on out_valid, held by out_stall.
//   record_valid tells whether date, start time and duration parsed; when
//   it is low every other field is zero.
//   Throughput: one byte per cycle while in_stall is low; the parse state is
//   updated by small logic in the cycle the byte is taken.
//   Result path: the edge that takes the closing beat loads the capture
//   register; the result then passes the seconds carry, minutes carry and
//   hour mod 24 registers on its way to the outputs.
//   Stall: the four result registers form a pipeline; input is held off
//   only when the capture register is full and cannot move on.
//   Reset: synchronous rst returns the parser to the first field and
//   empties the result pipeline.
module flight_record_info_parser_core #(
  parameter int DATE_FIELD_MAX_LENGTH = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       record_valid,
  output logic [15:0] year,
  output logic [7:0] month,
  output logic [7:0] day,
  output logic [7:0] start_hour,
  output logic [7:0] start_minute,
  output logic [7:0] start_second,
  output logic [4:0] end_hour,
  output logic [5:0] end_minute,
  output logic [5:0] end_second
);
  import frip_pkg::*;

  localparam int LenW = $clog2(DATE_FIELD_MAX_LENGTH + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(DATE_FIELD_MAX_LENGTH);

  // Parse state
  logic [2:0]      phase, phase_next;
  logic [1:0]      num_idx, num_idx_next;
  logic [LenW-1:0] field_len, field_len_next;
  logic            digits_seen, digits_seen_next;
  logic [15:0]     acc, acc_next;
  logic [15:0]     year_q, year_q_next;
  logic [7:0]      tf [0:7];
  logic [7:0]      tf_next [0:7];
  logic            failed, failed_next;
  logic            ended, ended_next;

  // Pipeline handshake
  logic accept;
  logic fin_vld, c1_vld, c2_vld;
  logic fin_ready, c1_ready, c2_ready, out_ready;

  // Per-byte decode
  logic        is_date, is_digit, is_space, is_sep;
  logic [7:0]  sep_char;
  logic [19:0] acc_scaled, acc_limit;
  logic        nb_fail, nb_store, nb_digits;
  logic [15:0] nb_acc;
  logic [1:0]  nb_idx;
  logic        ff_fail, ff_store;
  logic        do_store;
  logic [2:0]  store_slot;
  logic        rec_ok;

  // Result pipeline payload
  rec_head_t  fin_head, c1_head, c2_head;
  logic       fin_ok, c1_ok, c2_ok;
  logic [7:0] fin_dh, fin_dm, fin_ds, c1_dh;
  logic [8:0] sec_sum;
  logic [3:0] sec_carry, min_carry;
  logic [9:0] sec_rem, min_rem;
  logic [9:0] c1_m;
  logic [5:0] c1_sr, c2_sr, c2_mr;
  logic [9:0] c2_h;
  logic [19:0] hour_prod;
  logic [4:0]  hour_q;
  logic [9:0]  hour_rem;

  // Handshake: the capture register gates the input side
  assign out_ready = !out_valid || !out_stall;
  assign c2_ready  = !c2_vld || out_ready;
  assign c1_ready  = !c1_vld || c2_ready;
  assign fin_ready = !fin_vld || c1_ready;
  assign in_stall  = !fin_ready;
  assign accept    = in_valid && !in_stall;

  // Classify the incoming byte
  assign is_date  = (phase == PH_FIRST) || (phase == PH_DATE);
  assign sep_char = is_date ? CH_DASH : CH_COLON;
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_space = (text_byte == CH_SPACE) ||
                    ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign is_sep   = (text_byte == sep_char);
  assign acc_scaled = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} +
                      {16'b0, text_byte[3:0] - CH_ZERO[3:0]};
  assign acc_limit  = (is_date && (num_idx == 2'd0)) ? YEAR_LIMIT : NUM_LIMIT;

  // Effect of one byte inside a numeric field
  always_comb begin
    nb_acc    = acc;
    nb_digits = digits_seen;
    nb_idx    = num_idx;
    nb_fail   = 1'b0;
    nb_store  = 1'b0;
    if (num_idx != IDX_DONE) begin
      if (is_digit) begin
        nb_acc    = (acc_scaled > acc_limit) ? acc_limit[15:0] : acc_scaled[15:0];
        nb_digits = 1'b1;
      end else if (!digits_seen) begin
        nb_fail = !is_space;
      end else if (num_idx < 2'd2) begin
        if (is_sep) begin
          nb_store  = 1'b1;
          nb_idx    = num_idx + 2'd1;
          nb_digits = 1'b0;
          nb_acc    = 16'd0;
        end else begin
          nb_fail = 1'b1;
        end
      end else begin
        nb_store = 1'b1;
        nb_idx   = IDX_DONE;
      end
    end
  end

  // Effect of closing a numeric field at '|'
  assign ff_store = (num_idx == 2'd2) && digits_seen;
  assign ff_fail  = !ff_store && (num_idx != IDX_DONE);

  // Advance the parse state by one byte
  always_comb begin
    phase_next       = phase;
    num_idx_next     = num_idx;
    field_len_next   = field_len;
    digits_seen_next = digits_seen;
    acc_next         = acc;
    year_q_next      = year_q;
    tf_next          = tf;
    failed_next      = failed;
    ended_next       = ended;
    do_store         = 1'b0;
    if (!ended) begin
      if (text_byte == CH_NUL) begin
        ended_next = 1'b1;
      end else if (phase == PH_FIRST) begin
        if (text_byte == CH_BAR) begin
          if (field_len > LenMax) begin
            failed_next = 1'b0;
            phase_next  = PH_DATE;
          end else begin
            do_store    = ff_store;
            failed_next = failed || ff_fail;
            phase_next  = PH_START;
          end
          num_idx_next     = 2'd0;
          digits_seen_next = 1'b0;
          acc_next         = 16'd0;
        end else begin
          if (field_len <= LenMax) begin
            field_len_next = field_len + LenW'(1);
          end
          if ((field_len_next <= LenMax) && !failed) begin
            acc_next         = nb_acc;
            digits_seen_next = nb_digits;
            num_idx_next     = nb_idx;
            failed_next      = nb_fail;
            do_store         = nb_store;
          end
        end
      end else if (!failed) begin
        case (phase)
          PH_DATE, PH_START, PH_DUR: begin
            if (text_byte == CH_BAR) begin
              do_store         = ff_store;
              failed_next      = ff_fail;
              phase_next       = (phase == PH_DUR) ? PH_TAIL : phase + 3'd1;
              num_idx_next     = 2'd0;
              digits_seen_next = 1'b0;
              acc_next         = 16'd0;
            end else begin
              acc_next         = nb_acc;
              digits_seen_next = nb_digits;
              num_idx_next     = nb_idx;
              failed_next      = nb_fail;
              do_store         = nb_store;
            end
          end
          PH_TAIL: begin
            phase_next = PH_DONE;
          end
          default: begin
          end
        endcase
      end
    end

    // Store the finished number into its slot
    case (phase)
      PH_START: store_slot = 3'd2 + {1'b0, num_idx};
      PH_DUR:   store_slot = 3'd5 + {1'b0, num_idx};
      default:  store_slot = {1'b0, num_idx} - 3'd1;
    endcase
    if (do_store) begin
      if (is_date && (num_idx == 2'd0)) begin
        year_q_next = acc;
      end else begin
        tf_next[store_slot] = acc[7:0];
      end
    end
  end

  assign rec_ok = !failed_next && (phase_next == PH_DONE);

  // Hold parse state; clear it after each record
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_text)) begin
      phase       <= PH_FIRST;
      num_idx     <= 2'd0;
      field_len   <= '0;
      digits_seen <= 1'b0;
      acc         <= 16'd0;
      year_q      <= 16'd0;
      for (int i = 0; i < 8; i++) begin
        tf[i] <= 8'd0;
      end
      failed      <= 1'b0;
      ended       <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      num_idx     <= num_idx_next;
      field_len   <= field_len_next;
      digits_seen <= digits_seen_next;
      acc         <= acc_next;
      year_q      <= year_q_next;
      tf          <= tf_next;
      failed      <= failed_next;
      ended       <= ended_next;
    end
  end

  // Capture the finished record
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (accept && end_of_text) begin
      fin_vld <= 1'b1;
    end else if (c1_ready) begin
      fin_vld <= 1'b0;
    end
    if (accept && end_of_text) begin
      fin_ok <= rec_ok;
      if (rec_ok) begin
        fin_head <= '{year: year_q_next, month: tf_next[0], day: tf_next[1],
                      hour: tf_next[2], minute: tf_next[3], second: tf_next[4]};
        fin_dh   <= tf_next[5];
        fin_dm   <= tf_next[6];
        fin_ds   <= tf_next[7];
      end else begin
        fin_head <= '0;
        fin_dh   <= 8'd0;
        fin_dm   <= 8'd0;
        fin_ds   <= 8'd0;
      end
    end
  end

  // Seconds: add, carry into minutes
  assign sec_sum   = {1'b0, fin_head.second} + {1'b0, fin_ds};
  assign sec_carry = div60({1'b0, sec_sum});
  assign sec_rem   = {1'b0, sec_sum} - times60(sec_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
    end else if (c1_ready) begin
      c1_vld <= fin_vld;
    end
    if (c1_ready) begin
      c1_ok   <= fin_ok;
      c1_head <= fin_head;
      c1_dh   <= fin_dh;
      c1_sr   <= sec_rem[5:0];
      c1_m    <= {2'b0, fin_head.minute} + {2'b0, fin_dm} + {6'b0, sec_carry};
    end
  end

  // Minutes: carry into hours
  assign min_carry = div60(c1_m);
  assign min_rem   = c1_m - times60(min_carry);

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld <= 1'b0;
    end else if (c2_ready) begin
      c2_vld <= c1_vld;
    end
    if (c2_ready) begin
      c2_ok   <= c1_ok;
      c2_head <= c1_head;
      c2_sr   <= c1_sr;
      c2_mr   <= min_rem[5:0];
      c2_h    <= {2'b0, c1_head.hour} + {2'b0, c1_dh} + {6'b0, min_carry};
    end
  end

  // Hours: reduce mod 24 by reciprocal multiply
  assign hour_prod = c2_h * MOD24_RECIP;
  assign hour_q    = hour_prod[MOD24_SHIFT +: 5];
  assign hour_rem  = c2_h - {1'b0, hour_q, 4'b0} - {2'b0, hour_q, 3'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= c2_vld;
    end
    if (out_ready) begin
      record_valid <= c2_ok;
      year         <= c2_head.year;
      month        <= c2_head.month;
      day          <= c2_head.day;
      start_hour   <= c2_head.hour;
      start_minute <= c2_head.minute;
      start_second <= c2_head.second;
      end_hour     <= hour_rem[4:0];
      end_minute   <= c2_mr;
      end_second   <= c2_sr;
    end
  end

  // Input is held off only while the capture register is blocked
  assert property (@(posedge clk) disable iff (rst) in_stall |-> fin_vld)
    else $error("input stalled with empty capture register");

  // A closing beat returns the parser to the first field
  assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (phase == PH_FIRST) && (num_idx == 2'd0) && !failed)
    else $error("parser not cleared after record end");

  // End time stays within a day
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_hour < 5'd24) && (end_minute < 6'd60) && (end_second < 6'd60))
    else $error("end time out of range");

  // A rejected record carries zero fields
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !record_valid) |-> (year == 16'd0) && (end_hour == 5'd0) &&
                                     (end_minute == 6'd0) && (end_second == 6'd0))
    else $error("rejected record has nonzero fields");

  // First field length count saturates one past the limit
  assert property (@(posedge clk) disable iff (rst) field_len <= LenMax + LenW'(1))
    else $error("first field length overran");

endmodule
